>>> design/asd_pkg.sv
`timescale 1ns / 1ps
package asd_pkg;

  // window geometry
  localparam int unsigned WINDOW     = 16;
  localparam int unsigned WIN_BITS   = $clog2(WINDOW);
  localparam int unsigned MAG_W      = 16;
  localparam int unsigned SUM_W      = MAG_W + WIN_BITS;
  localparam int unsigned CMP_W      = SUM_W + 1;
  localparam int unsigned ROOT_STEPS = 16;
  localparam int unsigned CNT_W      = $clog2(ROOT_STEPS);

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 1'b1;
  localparam logic [CFG_DATA_W-1:0] THRESHOLD_RST = 16'd2000;
  localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RST  = 16'd300;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_DEC    = 2'd2
  } asd_op_e;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } asd_axis_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic [31:0]        time_ms;
    logic [31:0]        amount;
  } asd_in_t;

  typedef struct packed {
    logic [31:0]      step_count;
    logic             new_step;
    logic             decrement_ok;
    logic [MAG_W-1:0] magnitude;
  } asd_out_t;

  // controller to datapath
  typedef struct packed {
    logic      load;
    logic      sq_en;
    asd_axis_e sq_sel;
    logic      root_en;
    logic      upd;
    logic      cmp;
    logic      commit;
  } asd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_sample;
    logic out_free;
  } asd_sts_t;

endpackage

>>> design/asd_ctrl.sv
`timescale 1ns / 1ps
module asd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  asd_pkg::asd_sts_t sts_i,
  output asd_pkg::asd_cmd_t cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SQR  = 6'b000010,
    S_ROOT = 6'b000100,
    S_UPD  = 6'b001000,
    S_CMP  = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  state_e                      state_q, state_d;
  logic [asd_pkg::CNT_W-1:0]   cnt_q, cnt_d;

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    cmd_o          = '0;
    cmd_o.sq_sel   = asd_pkg::asd_axis_e'(cnt_q[1:0]);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = sts_i.in_sample ? S_SQR : S_DONE;
        end
      end
      S_SQR: begin
        cmd_o.sq_en = 1'b1;
        if (cnt_q[1:0] == asd_pkg::AXIS_Z) begin
          cnt_d   = '0;
          state_d = S_ROOT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_ROOT: begin
        cmd_o.root_en = 1'b1;
        cnt_d         = cnt_q + 1'b1;
        if (cnt_q == asd_pkg::CNT_W'(asd_pkg::ROOT_STEPS - 1)) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = S_CMP;
      end
      S_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> sts_i.out_free) else $error("commit while output busy");

  a_root_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |-> $past(state_q == S_ROOT) && $past(cnt_q) == '1)
    else $error("root iteration cut short");

endmodule

>>> design/asd_datapath.sv
`timescale 1ns / 1ps
module asd_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  asd_pkg::asd_cmd_t                cmd_i,
  output asd_pkg::asd_sts_t                sts_o,
  input  asd_pkg::asd_in_t                 in_word_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output asd_pkg::asd_out_t                out_word_o,
  input  logic                             cfg_we_i,
  input  logic [asd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [asd_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned MW = asd_pkg::MAG_W;
  localparam int unsigned SW = asd_pkg::SUM_W;
  localparam int unsigned CW = asd_pkg::CMP_W;
  localparam int unsigned WB = asd_pkg::WIN_BITS;

  asd_pkg::asd_in_t   item_q;
  logic [31:0]        rad_q, rad_d;
  logic [MW:0]        rem_q, rem_d;
  logic [MW-1:0]      root_q, root_d;
  logic [MW-1:0]      win_q [asd_pkg::WINDOW];
  logic [WB-1:0]      wpos_q;
  logic [SW-1:0]      sum_q, sum_d;
  logic               above_q, dbok_q, cand_q;
  logic [31:0]        last_q, steps_q;
  logic [15:0]        thr_q, deb_q;
  logic               out_valid_q;
  asd_pkg::asd_out_t  out_q, out_d;

  // one square per cycle
  logic signed [15:0] axis_val;
  logic [16:0]        axis_abs;
  logic [33:0]        axis_sq;

  always_comb begin
    unique case (cmd_i.sq_sel)
      asd_pkg::AXIS_X: axis_val = item_q.accel_x;
      asd_pkg::AXIS_Y: axis_val = item_q.accel_y;
      default:         axis_val = item_q.accel_z;
    endcase
    axis_abs = axis_val[15] ? 17'(-{axis_val[15], axis_val}) : {1'b0, axis_val};
    axis_sq  = axis_abs * axis_abs;
  end

  // restoring square root, one result bit per step
  logic [MW+2:0] rem_sh, trial;

  always_comb begin
    rem_sh = {rem_q, rad_q[31:30]};
    trial  = {1'b0, root_q, 2'b01};
    if (rem_sh >= trial) begin
      rem_d  = (MW+1)'(rem_sh - trial);
      root_d = {root_q[MW-2:0], 1'b1};
    end else begin
      rem_d  = rem_sh[MW:0];
      root_d = {root_q[MW-2:0], 1'b0};
    end
    rad_d = {rad_q[29:0], 2'b00};
  end

  // window update and threshold compare
  logic [CW-1:0] lhs, rhs;
  logic [31:0]   elapsed;

  assign sum_d   = sum_q - SW'(win_q[wpos_q]) + SW'(root_q);
  assign elapsed = item_q.time_ms - last_q;
  assign lhs     = CW'(root_q) * CW'(asd_pkg::WINDOW);
  assign rhs     = CW'(sum_q) + CW'(thr_q) * CW'(asd_pkg::WINDOW);

  // commit of one item
  logic [31:0] steps_d, last_d;
  logic        above_d;

  always_comb begin
    steps_d = steps_q;
    last_d  = last_q;
    above_d = above_q;
    out_d   = '0;
    unique case (asd_pkg::asd_op_e'(item_q.opcode))
      asd_pkg::OP_SAMPLE: begin
        out_d.magnitude = root_q;
        if (cand_q) begin
          if (!above_q && dbok_q) begin
            if (steps_q != '1) begin
              steps_d = steps_q + 32'd1;
            end
            above_d        = 1'b1;
            last_d         = item_q.time_ms;
            out_d.new_step = 1'b1;
          end
        end else begin
          above_d = 1'b0;
        end
      end
      asd_pkg::OP_CLEAR: begin
        steps_d = '0;
      end
      asd_pkg::OP_DEC: begin
        if (steps_q >= item_q.amount) begin
          steps_d            = steps_q - item_q.amount;
          out_d.decrement_ok = 1'b1;
        end
      end
      default: ;
    endcase
    out_d.step_count = steps_d;
  end

  assign sts_o.in_sample = (in_word_i.opcode == asd_pkg::OP_SAMPLE);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign out_word_o      = out_q;

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_word_i;
    end
    if (cmd_i.commit) begin
      out_q <= out_d;
    end
    if (cmd_i.upd) begin
      dbok_q <= (elapsed > 32'(deb_q));
    end
    if (cmd_i.cmp) begin
      cand_q <= (lhs > rhs);
    end
  end

  // square root working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rad_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.sq_en) begin
      rad_q <= rad_q + axis_sq[31:0];
    end else if (cmd_i.root_en) begin
      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  // detector state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(asd_pkg::WINDOW); i++) begin
        win_q[i] <= '0;
      end
      wpos_q      <= '0;
      sum_q       <= '0;
      above_q     <= 1'b0;
      last_q      <= '0;
      steps_q     <= '0;
      thr_q       <= asd_pkg::THRESHOLD_RST;
      deb_q       <= asd_pkg::DEBOUNCE_RST;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          asd_pkg::CFG_THRESHOLD: thr_q <= cfg_data_i;
          default:                deb_q <= cfg_data_i;
        endcase
      end
      if (cmd_i.upd) begin
        win_q[wpos_q] <= root_q;
        sum_q         <= sum_d;
        wpos_q        <= (wpos_q == WB'(asd_pkg::WINDOW - 1)) ? '0 : wpos_q + 1'b1;
      end
      if (cmd_i.commit) begin
        steps_q     <= steps_d;
        last_q      <= last_d;
        above_q     <= above_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  a_step_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.new_step |-> out_q.magnitude != '0)
    else $error("step counted with zero magnitude");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.new_step && out_q.decrement_ok))
    else $error("step and decrement in one word");

  a_step_above: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && out_d.new_step |=> above_q)
    else $error("above flag not set after step");

endmodule

>>> design/accel_step_detector.sv
`timescale 1ns / 1ps
// accelerometer step detector
// input channel (in_valid_i / in_stall_o / in_word_i) carries one word per
// operation: a sample (x, y, z, time_ms), a count clear or a count decrement
// output channel (out_valid_o / out_stall_i / out_word_o) returns exactly one
// word per input word, in order: step count, new step, decrement ok, magnitude
// configuration: cfg_we_i writes cfg_data_i to the register at cfg_idx_i
// (0 rise threshold, 1 debounce time); write only while the block is idle
// a sample passes through squaring of the three axes on the one shared
// 17x17 squarer, the bit-per-cycle square root, the window update, the
// compare and the commit, which waits until the output register is free;
// clear and decrement go from accept straight to the commit; a new word can
// be accepted in the cycle after the commit, and the input stalls until then
// the output register lets the next word enter and compute while a result
// is still stalled; the finished word then waits in its commit cycle
// reset clears the window, running sum, flags and count at once and loads
// the default threshold and debounce time; no clearing pass is needed
module accel_step_detector (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  asd_pkg::asd_in_t                in_word_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output asd_pkg::asd_out_t               out_word_o,
  input  logic                            cfg_we_i,
  input  logic [asd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [asd_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  // command and status between sequencer and datapath
  asd_pkg::asd_cmd_t cmd;
  asd_pkg::asd_sts_t sts;

  // sequencer: idle, square, root, window update, compare, commit
  asd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // arithmetic, window store, detector state and output register
  asd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

endmodule

>>> tb/asd_checker.sv
`timescale 1ns / 1ps
module asd_checker
  import asd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  asd_in_t               in_word_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  asd_out_t              out_word_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned           mismatch_count_o,
  output int unsigned           pending_o
);

  // shadow of the detector state
  logic [MAG_W-1:0]      mag_hist [WINDOW];
  logic [WIN_BITS-1:0]   hist_pos;
  logic [SUM_W-1:0]      hist_sum;
  logic                  above;
  logic [31:0]           last_step_ms;
  logic [31:0]           step_total;
  logic [CFG_DATA_W-1:0] rise_thr;
  logic [CFG_DATA_W-1:0] debounce;

  asd_out_t    expected_words [$];
  int unsigned mismatches = 0;

  function automatic logic [31:0] abs16(input logic [15:0] v);
    return v[15] ? 32'h0001_0000 - {16'd0, v} : {16'd0, v};
  endfunction

  // advances the shadow state by one word and returns the word it should produce
  function automatic asd_out_t detect_step(input asd_in_t w);
    asd_out_t    r;
    logic [31:0] ax, ay, az, rem, root, probe;
    logic [39:0] lhs, rhs;
    r = '0;
    case (w.opcode)
      OP_SAMPLE: begin
        ax = abs16(w.accel_x);
        ay = abs16(w.accel_y);
        az = abs16(w.accel_z);
        rem = ax * ax + ay * ay + az * az;
        // floor square root, one result bit per pass over two radicand bits
        root = '0;
        probe = 32'h4000_0000;
        while (probe > rem) probe = probe >> 2;
        while (probe != 0) begin
          if (rem >= root + probe) begin
            rem = rem - (root + probe);
            root = (root >> 1) + probe;
          end else begin
            root = root >> 1;
          end
          probe = probe >> 2;
        end
        r.magnitude = root[MAG_W-1:0];
        hist_sum = hist_sum - mag_hist[hist_pos] + r.magnitude;
        mag_hist[hist_pos] = r.magnitude;
        hist_pos = (hist_pos == WIN_BITS'(WINDOW - 1)) ? '0 : hist_pos + 1'b1;
        lhs = 40'(WINDOW) * r.magnitude;
        rhs = 40'(hist_sum) + 40'(WINDOW) * rise_thr;
        if (lhs > rhs) begin
          if (!above && (w.time_ms - last_step_ms) > {16'd0, debounce}) begin
            if (step_total != '1) step_total = step_total + 1'b1;
            above = 1'b1;
            last_step_ms = w.time_ms;
            r.new_step = 1'b1;
          end
        end else begin
          above = 1'b0;
        end
      end
      OP_CLEAR: step_total = '0;
      OP_DEC: begin
        if (step_total >= w.amount) begin
          step_total = step_total - w.amount;
          r.decrement_ok = 1'b1;
        end
      end
      default: ;
    endcase
    r.step_count = step_total;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    asd_out_t want;
    if (!rst_ni) begin
      foreach (mag_hist[i]) mag_hist[i] = '0;
      hist_pos = '0;
      hist_sum = '0;
      above = 1'b0;
      last_step_ms = '0;
      step_total = '0;
      rise_thr = THRESHOLD_RST;
      debounce = DEBOUNCE_RST;
      expected_words.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_THRESHOLD) rise_thr = cfg_data_i;
        else if (cfg_idx_i == CFG_DEBOUNCE) debounce = cfg_data_i;
      end
      // result side first so a word never meets its own prediction early
      if (out_valid_i && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result word with nothing pending: count %0d new %0b dec %0b mag %0d",
                     $time, out_word_i.step_count, out_word_i.new_step,
                     out_word_i.decrement_ok, out_word_i.magnitude);
        end else begin
          want = expected_words.pop_front();
          if (want.step_count !== out_word_i.step_count ||
              want.new_step !== out_word_i.new_step ||
              want.decrement_ok !== out_word_i.decrement_ok ||
              want.magnitude !== out_word_i.magnitude) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: result differs: expected count %0d new %0b dec %0b mag %0d, got %0d %0b %0b %0d",
                       $time, want.step_count, want.new_step, want.decrement_ok,
                       want.magnitude, out_word_i.step_count, out_word_i.new_step,
                       out_word_i.decrement_ok, out_word_i.magnitude);
          end
        end
      end
      if (in_valid_i && !in_stall_i) expected_words.push_back(detect_step(in_word_i));
    end
    mismatch_count_o <= mismatches;
    pending_o <= expected_words.size();
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import asd_pkg::*;

  // opcode value the block does not define
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam int unsigned GAP_MAX      = 18;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned PHASE_WORDS  = 200;
  localparam int unsigned PHASES       = 8;

  // how both sides pace themselves in a phase
  typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_MIXED} idle_style_e;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  asd_in_t               in_word;
  logic                  out_valid;
  logic                  out_stall;
  asd_out_t              out_word;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int unsigned           mismatches;
  int unsigned           pending;

  idle_style_e idle_style;
  bit          hold_req;
  int unsigned quiet_cycles;

  // walking pattern state: running clock and position within one stride
  logic [31:0] clock_ms;
  int unsigned gait_pos;
  int unsigned gait_len;

  accel_step_detector dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  asd_checker step_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_word_i        (in_word),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_word_i       (out_word),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // per-word wait drawn by either side
  function automatic int unsigned draw_gap();
    case (idle_style)
      IDLE_NONE:  return 0;
      IDLE_MIXED: return ($urandom_range(1) == 0) ? 0 : $urandom_range(GAP_MAX);
      default:    return $urandom_range(GAP_MAX);
    endcase
  endfunction

  // offer one word and hold it until the block takes it
  // called at a rising edge; valid stays high when no gap is drawn
  task automatic send_word(input asd_in_t w);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_sample(input int x, input int y, input int z, input logic [31:0] t);
    asd_in_t w;
    w.opcode  = OP_SAMPLE;
    w.accel_x = 16'(x);
    w.accel_y = 16'(y);
    w.accel_z = 16'(z);
    w.time_ms = t;
    w.amount  = $urandom;
    send_word(w);
  endtask

  // count operations carry random junk in the sample fields
  task automatic send_op(input logic [1:0] op, input logic [31:0] amount);
    asd_in_t w;
    w.opcode  = op;
    w.accel_x = 16'($urandom);
    w.accel_y = 16'($urandom);
    w.accel_z = 16'($urandom);
    w.time_ms = $urandom;
    w.amount  = amount;
    send_word(w);
  endtask

  // both registers, back to back, only while the block is idle
  task automatic set_config(input logic [CFG_DATA_W-1:0] thr, input logic [CFG_DATA_W-1:0] deb);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_THRESHOLD;
    cfg_data <= thr;
    @(posedge clk);
    cfg_idx  <= CFG_DEBOUNCE;
    cfg_data <= deb;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // one edge first so the last accepted word is already counted as pending
  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // mostly a walking pattern: a quiet baseline near one g with a heel strike
  // every few samples and a clock that moves forward; the rest is count
  // operations, the undefined opcode and samples of pure noise
  task automatic make_gait_word(output asd_in_t w);
    int unsigned   pick;
    int unsigned   spike;
    logic [127:0]  noise;
    logic [15:0]   rail;
    pick = $urandom_range(99);
    noise = {$urandom, $urandom, $urandom, $urandom};
    w = noise[$bits(asd_in_t)-1:0];
    if (pick < 78) begin
      w.opcode = OP_SAMPLE;
      case ($urandom_range(49))
        0:             clock_ms = $urandom;            // far jump, may wrap
        1, 2, 3, 4, 5: clock_ms += $urandom_range(70000); // long pause
        default:       clock_ms += $urandom_range(60, 4);
      endcase
      w.time_ms = clock_ms;
      if (gait_pos == 0) begin
        if ($urandom_range(19) == 0) begin
          // rail-to-rail strike
          rail = $urandom_range(1) ? 16'h7FFF : 16'h8000;
          w.accel_x = rail;
          w.accel_y = $urandom_range(1) ? 16'h7FFF : 16'h8000;
          w.accel_z = rail;
        end else begin
          spike = $urandom_range(32767, 12000);
          w.accel_x = 16'(int'($urandom_range(20000)) - 10000);
          w.accel_y = 16'(int'($urandom_range(20000)) - 10000);
          w.accel_z = $urandom_range(1) ? 16'(spike) : 16'(-int'(spike));
        end
      end else begin
        w.accel_x = 16'(int'($urandom_range(3000)) - 1500);
        w.accel_y = 16'(int'($urandom_range(3000)) - 1500);
        w.accel_z = 16'(16384 + int'($urandom_range(3000)) - 1500);
        if ($urandom_range(9) == 0) w.accel_z = -w.accel_z;
      end
      if (gait_pos + 1 >= gait_len) begin
        gait_pos = 0;
        gait_len = $urandom_range(8, 2);
      end else begin
        gait_pos++;
      end
    end else if (pick < 84) begin
      w.opcode = OP_DEC;
      if ($urandom_range(3) != 0) w.amount = $urandom_range(4);
    end else if (pick < 86) begin
      w.opcode = OP_CLEAR;
    end else if (pick < 89) begin
      w.opcode = OP_UNUSED;
    end else begin
      w.opcode = OP_SAMPLE;   // noise sample, every field random
    end
  endtask

  // result side: random stall per word, plus one long hold-off on request
  initial begin
    int unsigned gap;
    out_stall <= 1'b0;
    forever begin
      if (hold_req) begin
        // block keeps taking words until it is full, then stalls its input
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      gap = draw_gap();
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // watchdog: ends a run that stops moving words in either direction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    asd_in_t               w;
    logic [CFG_DATA_W-1:0] thr;
    logic [CFG_DATA_W-1:0] deb;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_word    <= '0;
    cfg_we     <= 1'b0;
    cfg_idx    <= '0;
    cfg_data   <= '0;
    idle_style = IDLE_MIXED;
    hold_req   = 1'b0;
    clock_ms   = 32'd2000;
    gait_pos   = 0;
    gait_len   = 4;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words under the reset threshold and debounce time
    send_sample(0, 0, 0, 32'd0);                           // empty window, zero magnitude
    send_sample(-32768, -32768, -32768, 32'd301);          // largest magnitude, first step
    send_sample(-32768, -32768, -32768, 32'd302);          // still above, flag blocks it
    send_sample(0, 0, 0, 32'd400);                         // drop below, flag clears
    send_sample(32767, 32767, 32767, 32'd601);             // exactly debounce apart, no step
    send_sample(32767, -32768, 32767, 32'd602);            // one past debounce, counts
    send_op(OP_DEC, 32'd0);                                // zero decrement succeeds
    send_op(OP_DEC, 32'd3);                                // more than the count, refused
    send_op(OP_DEC, 32'd2);                                // down to zero
    send_op(OP_DEC, 32'hFFFF_FFFF);                        // largest amount, refused
    send_op(OP_UNUSED, 32'hFFFF_FFFF);                     // undefined opcode changes nothing
    send_sample(0, 0, 0, 32'd700);
    send_sample(-32768, -32768, -32768, 32'hFFFF_FFF0);    // just before the clock wraps
    send_sample(1, 1, 1, 32'hFFFF_FFF8);
    send_sample(-32768, 32767, -32768, 32'h0000_0120);     // elapsed time across the wrap
    send_op(OP_CLEAR, $urandom);                           // clears the count only
    send_sample(100, -200, 16000, 32'd1000);
    in_valid <= 1'b0;
    wait_drained();

    // both registers at zero: any rise over the average counts
    set_config('0, '0);
    send_sample(0, 0, 0, 32'd1100);
    send_sample(-32768, -32768, -32768, 32'd1100);
    send_sample(0, 0, 0, 32'd1100);
    send_sample(-32768, -32768, -32768, 32'd1100);         // no time elapsed, no step
    send_sample(32767, 32767, 32767, 32'd1101);            // one ms later counts
    in_valid <= 1'b0;
    wait_drained();

    // random phases, each with its own settings and pacing
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin thr = THRESHOLD_RST; deb = DEBOUNCE_RST; idle_style = IDLE_FULL; end
        1: begin thr = '0; deb = '0; idle_style = IDLE_NONE; end
        2: begin thr = '1; deb = '1; idle_style = IDLE_MIXED; end
        3: begin
          thr = 16'($urandom_range(6000));
          deb = 16'($urandom_range(400));
          idle_style = IDLE_FULL;
        end
        4: begin thr = 16'd56756; deb = '0; idle_style = IDLE_NONE; end
        5: begin thr = 16'($urandom); deb = 16'($urandom); idle_style = IDLE_MIXED; end
        6: begin
          thr = 16'($urandom_range(3000));
          deb = 16'($urandom_range(200));
          idle_style = IDLE_NONE;
        end
        default: begin thr = 16'($urandom_range(2000)); deb = '1; idle_style = IDLE_FULL; end
      endcase
      set_config(thr, deb);
      for (int unsigned i = 0; i < PHASE_WORDS; i++) begin
        // long receiver hold-off while words keep coming
        if (phase == 3 && i == 40) hold_req = 1'b1;
        make_gait_word(w);
        send_word(w);
      end
      in_valid <= 1'b0;
      wait_drained();
    end

    // let any stray result show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
